FILE: rtl/core/cdau_pkg.sv
package cdau_pkg;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] amount;
  } req_t;

  typedef struct packed {
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [13:0] year_now;
    logic [1:0]  status;
  } rsp_t;

  localparam logic [2:0] MODE_SET_DAY   = 3'd0;
  localparam logic [2:0] MODE_SET_MONTH = 3'd1;
  localparam logic [2:0] MODE_SET_YEAR  = 3'd2;
  localparam logic [2:0] MODE_ADD_DAYS  = 3'd3;
  localparam logic [2:0] MODE_ADD_MONTH = 3'd4;
  localparam logic [2:0] MODE_ADD_YEARS = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_LOW    = 2'd2;
  localparam logic [1:0] ST_HIGH   = 2'd3;

  // y * LEAP_MUL mod 2^14 <= DIV25_LIM exactly when y is a multiple of 25
  localparam logic [15:0] LEAP_MUL  = 16'd7209;
  localparam logic [13:0] DIV25_LIM = 14'd655;
  // (t * DIV3_MUL) >> 17 is t / 3 for every 16-bit t
  localparam logic [15:0] DIV3_MUL  = 16'd43691;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET,
    S_YCAND,
    S_YCHK,
    S_ADDY,
    S_MTOT,
    S_MDIV,
    S_MSPLIT,
    S_DSTEP,
    S_LEAP,
    S_LEAPWB,
    S_CLAMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic bound;
    logic days_fin;
    logic year_wrap;
    logic is_days;
    logic rsp_free;
  } flg_t;

  typedef struct packed {
    state_t state;
    logic   req_ready;
    logic   mul_div;
    logic   rsp_load;
  } ctl_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2: r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // p is the low 14 bits of y * LEAP_MUL
  function automatic logic leap_of(input logic [13:0] y, input logic [13:0] p);
    return (y[1:0] == 2'b00) && ((p > DIV25_LIM) || (y[3:0] == 4'b0000));
  endfunction

endpackage

FILE: rtl/core/cdau_mul.sv
module cdau_mul (
  input  logic        clk,
  input  logic [15:0] a,
  input  logic        div,
  output logic [31:0] prod
);

  logic [15:0] b;

  assign b = div ? cdau_pkg::DIV3_MUL : cdau_pkg::LEAP_MUL;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: rtl/core/cdau_fsm.sv
module cdau_fsm (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [2:0]     req_mode,
  input  cdau_pkg::flg_t flg,
  output cdau_pkg::ctl_t ctl
);

  cdau_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdau_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (req_mode)
            cdau_pkg::MODE_SET_YEAR:  state_next = cdau_pkg::S_YCAND;
            cdau_pkg::MODE_ADD_DAYS:  state_next = cdau_pkg::S_DSTEP;
            cdau_pkg::MODE_ADD_MONTH: state_next = cdau_pkg::S_MTOT;
            cdau_pkg::MODE_ADD_YEARS: state_next = cdau_pkg::S_ADDY;
            default:                  state_next = cdau_pkg::S_SET;
          endcase
        end
      end
      cdau_pkg::S_SET:   state_next = cdau_pkg::S_FINISH;
      cdau_pkg::S_YCAND: state_next = cdau_pkg::S_YCHK;
      cdau_pkg::S_YCHK:  state_next = cdau_pkg::S_FINISH;
      cdau_pkg::S_ADDY:  state_next = flg.bound ? cdau_pkg::S_FINISH : cdau_pkg::S_LEAP;
      cdau_pkg::S_MTOT:  state_next = flg.bound ? cdau_pkg::S_FINISH : cdau_pkg::S_MDIV;
      cdau_pkg::S_MDIV:  state_next = cdau_pkg::S_MSPLIT;
      cdau_pkg::S_MSPLIT: state_next = flg.bound ? cdau_pkg::S_FINISH : cdau_pkg::S_LEAP;
      cdau_pkg::S_DSTEP: begin
        priority if (flg.days_fin) begin
          state_next = cdau_pkg::S_FINISH;
        end else if (flg.year_wrap) begin
          state_next = cdau_pkg::S_LEAP;
        end else begin
          state_next = cdau_pkg::S_DSTEP;
        end
      end
      cdau_pkg::S_LEAP:   state_next = cdau_pkg::S_LEAPWB;
      cdau_pkg::S_LEAPWB: state_next = flg.is_days ? cdau_pkg::S_DSTEP : cdau_pkg::S_CLAMP;
      cdau_pkg::S_CLAMP:  state_next = cdau_pkg::S_FINISH;
      cdau_pkg::S_FINISH: begin
        if (flg.rsp_free) begin
          state_next = cdau_pkg::S_IDLE;
        end
      end
      default: state_next = cdau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.state     = state;
    ctl.req_ready = (state == cdau_pkg::S_IDLE);
    ctl.mul_div   = (state == cdau_pkg::S_MDIV);
    ctl.rsp_load  = (state == cdau_pkg::S_FINISH) && flg.rsp_free;
  end

endmodule

FILE: rtl/core/calendar_date_adjust_unit.sv
// Channel  Handshake               Payload  Word
// request  req_valid / req_ready   req      mode, amount
// response rsp_valid / rsp_ready   rsp      day_now, month_now, year_now, status
//
// One request at a time; req_ready is high only while the unit is idle.
// Set day and month run S_SET, set year S_YCAND and S_YCHK; add years runs
// S_ADDY, add months S_MTOT, S_MDIV, S_MSPLIT, both then S_LEAP, S_LEAPWB,
// S_CLAMP; an add that clamps or saturates ends sooner. Add days steps one month
// per cycle, leaving the loop at each year crossed for the leap recompute on the shared multiplier.
// A finished result waits in the response register; the unit takes the next
// request while it waits, and stalls its next result until the slot frees.
// Reset (rst, synchronous) sets the date to 1.1.1 and empties the response.
module calendar_date_adjust_unit #(
  parameter int MAX_YEAR = 9999
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cdau_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cdau_pkg::rsp_t rsp
);

  localparam logic [13:0] MaxYr   = 14'(MAX_YEAR);
  localparam logic        MaxLeap = ((MAX_YEAR % 4 == 0) && (MAX_YEAR % 100 != 0))
                                    || (MAX_YEAR % 400 == 0);

  cdau_pkg::ctl_t ctl;
  cdau_pkg::flg_t flg;

  logic [4:0]  day, day_next;
  logic [3:0]  month, month_next;
  logic [13:0] year, year_next;
  logic        leap, leap_next;
  logic [2:0]  mode_r, mode_r_next;
  logic signed [15:0] amt_r, amt_r_next;
  logic [15:0] n_cnt, n_cnt_next;
  logic        neg, neg_next;
  logic signed [18:0] total, total_next;
  logic [1:0]  st, st_next;

  logic [15:0] mul_a;
  logic [31:0] prod;
  logic [4:0]  len_cur;
  logic [4:0]  rem;
  logic [18:0] year_x12;
  logic signed [18:0] total_c;
  logic signed [16:0] ny;
  logic [14:0] q;
  logic [17:0] q12;
  logic [17:0] mrem;
  logic        go_low, go_high;
  logic        ok;

  cdau_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .flg       (flg),
    .ctl       (ctl)
  );

  always_comb begin
    unique case (ctl.state)
      cdau_pkg::S_YCAND: mul_a = amt_r;
      cdau_pkg::S_MDIV:  mul_a = total[17:2];
      default:           mul_a = {2'b00, year};
    endcase
  end

  cdau_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .div  (ctl.mul_div),
    .prod (prod)
  );

  assign req_ready = ctl.req_ready;

  assign len_cur  = cdau_pkg::month_len(month, leap);
  assign rem      = len_cur - day;
  assign year_x12 = ({5'b0, year} << 3) + ({5'b0, year} << 2);
  assign total_c  = $signed(year_x12) + $signed({15'b0, month}) - 19'sd1
                    + $signed({{3{amt_r[15]}}, amt_r});
  assign ny       = $signed({3'b000, year}) + $signed({amt_r[15], amt_r});
  assign q        = prod[31:17];
  assign q12      = ({3'b000, q} << 3) + ({3'b000, q} << 2);
  assign mrem     = total[17:0] - q12;

  always_comb begin
    day_next    = day;
    month_next  = month;
    year_next   = year;
    leap_next   = leap;
    mode_r_next = mode_r;
    amt_r_next  = amt_r;
    n_cnt_next  = n_cnt;
    neg_next    = neg;
    total_next  = total;
    st_next     = st;
    go_low      = 1'b0;
    go_high     = 1'b0;
    ok          = 1'b0;
    flg.days_fin  = 1'b0;
    flg.year_wrap = 1'b0;
    flg.is_days   = (mode_r == cdau_pkg::MODE_ADD_DAYS);
    flg.rsp_free  = !rsp_valid || rsp_ready;

    unique case (ctl.state)
      cdau_pkg::S_IDLE: begin
        if (req_valid) begin
          mode_r_next = req.mode;
          amt_r_next  = req.amount;
          neg_next    = req.amount[15];
          n_cnt_next  = req.amount[15] ? (~req.amount + 16'd1) : req.amount;
          st_next     = cdau_pkg::ST_OK;
        end
      end
      cdau_pkg::S_SET: begin
        if (mode_r == cdau_pkg::MODE_SET_DAY) begin
          ok = !amt_r[15] && (amt_r[14:5] == 10'd0) && (amt_r[4:0] != 5'd0)
               && (amt_r[4:0] <= len_cur);
          if (ok) day_next = amt_r[4:0];
          else    st_next  = cdau_pkg::ST_REJECT;
        end else if (mode_r == cdau_pkg::MODE_SET_MONTH) begin
          ok = !amt_r[15] && (amt_r[14:4] == 11'd0) && (amt_r[3:0] != 4'd0)
               && (amt_r[3:0] <= 4'd12)
               && (day <= cdau_pkg::month_len(amt_r[3:0], leap));
          if (ok) month_next = amt_r[3:0];
          else    st_next    = cdau_pkg::ST_REJECT;
        end
      end
      cdau_pkg::S_YCHK: begin
        ok = !amt_r[15] && (amt_r != 16'sd0) && (amt_r[14:0] <= {1'b0, MaxYr})
             && (day <= cdau_pkg::month_len(month,
                          cdau_pkg::leap_of(amt_r[13:0], prod[13:0])));
        if (ok) begin
          year_next = amt_r[13:0];
          leap_next = cdau_pkg::leap_of(amt_r[13:0], prod[13:0]);
        end else begin
          st_next = cdau_pkg::ST_REJECT;
        end
      end
      cdau_pkg::S_ADDY: begin
        priority if (ny[16] || (ny == 17'sd0)) begin
          go_low = 1'b1;
        end else if (ny > $signed({3'b000, MaxYr})) begin
          go_high = 1'b1;
        end else begin
          year_next = ny[13:0];
        end
      end
      cdau_pkg::S_MTOT: begin
        total_next = total_c;
        if (total_c < 19'sd12) go_low = 1'b1;
      end
      cdau_pkg::S_MSPLIT: begin
        if (q > {1'b0, MaxYr}) begin
          go_high = 1'b1;
        end else begin
          year_next  = q[13:0];
          month_next = mrem[3:0] + 4'd1;
        end
      end
      cdau_pkg::S_DSTEP: begin
        if (!neg) begin
          if (n_cnt <= {11'b0, rem}) begin
            day_next     = day + n_cnt[4:0];
            flg.days_fin = 1'b1;
          end else begin
            n_cnt_next = n_cnt - ({11'b0, rem} + 16'd1);
            day_next   = 5'd1;
            if (month == 4'd12) begin
              month_next = 4'd1;
              if (year >= MaxYr) begin
                go_high      = 1'b1;
                flg.days_fin = 1'b1;
              end else begin
                year_next     = year + 14'd1;
                flg.year_wrap = 1'b1;
              end
            end else begin
              month_next = month + 4'd1;
            end
          end
        end else begin
          if (n_cnt < {11'b0, day}) begin
            day_next     = day - n_cnt[4:0];
            flg.days_fin = 1'b1;
          end else begin
            n_cnt_next = n_cnt - {11'b0, day};
            if (month == 4'd1) begin
              if (year <= 14'd1) begin
                go_low       = 1'b1;
                flg.days_fin = 1'b1;
              end else begin
                // December is 31 days whatever the year
                year_next     = year - 14'd1;
                month_next    = 4'd12;
                day_next      = 5'd31;
                flg.year_wrap = 1'b1;
              end
            end else begin
              month_next = month - 4'd1;
              day_next   = cdau_pkg::month_len(month - 4'd1, leap);
            end
          end
        end
      end
      cdau_pkg::S_LEAPWB: begin
        leap_next = cdau_pkg::leap_of(year, prod[13:0]);
      end
      cdau_pkg::S_CLAMP: begin
        if (day > len_cur) day_next = len_cur;
      end
      default: begin
      end
    endcase

    flg.bound = go_low || go_high;

    if (go_low) begin
      day_next   = 5'd1;
      month_next = 4'd1;
      year_next  = 14'd1;
      leap_next  = 1'b0;
      st_next    = cdau_pkg::ST_LOW;
    end else if (go_high) begin
      day_next   = 5'd31;
      month_next = 4'd12;
      year_next  = MaxYr;
      leap_next  = MaxLeap;
      st_next    = cdau_pkg::ST_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= 5'd1;
      month <= 4'd1;
      year  <= 14'd1;
      leap  <= 1'b0;
    end else begin
      day   <= day_next;
      month <= month_next;
      year  <= year_next;
      leap  <= leap_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_r_next;
    amt_r  <= amt_r_next;
    n_cnt  <= n_cnt_next;
    neg    <= neg_next;
    total  <= total_next;
    st     <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rsp_load) begin
      rsp.day_now   <= day;
      rsp.month_now <= month;
      rsp.year_now  <= year;
      rsp.status    <= st;
    end
  end

endmodule

FILE: rtl/core/cdau_checker.sv
module cdau_checker #(
  parameter int MAX_YEAR = 9999
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input cdau_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input cdau_pkg::rsp_t rsp
);

  localparam logic [13:0] MaxYr = 14'(MAX_YEAR);

  // hold the response word until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a word is in work");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.day_now >= 5'd1) && (rsp.month_now >= 4'd1)
                  && (rsp.month_now <= 4'd12) && (rsp.year_now >= 14'd1)
                  && (rsp.year_now <= MaxYr))
    else $error("response date out of range");

  a_high: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == cdau_pkg::ST_HIGH) |->
      (rsp.day_now == 5'd31) && (rsp.month_now == 4'd12) && (rsp.year_now == MaxYr))
    else $error("saturated result is not the last day");

  a_low: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == cdau_pkg::ST_LOW) |->
      (rsp.day_now == 5'd1) && (rsp.month_now == 4'd1) && (rsp.year_now == 14'd1))
    else $error("clamped result is not the first day");

endmodule

bind calendar_date_adjust_unit cdau_checker #(.MAX_YEAR(MAX_YEAR)) u_cdau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
